/* hw/rtl/mciq_pkg.sv */
// Package for the multi-channel input qualifier.
// Holds register indexes, reset values, widths and the threshold bundle.
// No dependencies.
package mciq_pkg;

    // Default channel count and fixed field widths
    localparam int CHANNELS_DEF = 3;
    localparam int CNT_W        = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TICKS   = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] MODES_RESET = 16'd6;
    localparam logic [CNT_W-1:0] PRESS_RESET = 16'd10;
    localparam logic [CNT_W-1:0] HOLD_RESET  = 16'd1000;
    localparam logic [CNT_W-1:0] LEVEL_RESET = 16'd40;

    // Tick thresholds shared by all channels
    typedef struct packed {
        logic [CNT_W-1:0] press;
        logic [CNT_W-1:0] hold;
        logic [CNT_W-1:0] level;
    } mciq_thr_t;

endpackage

/* hw/rtl/mciq_channel.sv */
// One qualifier channel: tick counter and held state, button or sensor mode.
// Depends on mciq_pkg.
module mciq_channel (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,       // one scan tick is processed
    input  logic              mode,     // 0 button, 1 sensor
    input  logic              active,   // pin level low
    input  mciq_pkg::mciq_thr_t thr,
    output logic              evt,
    output logic              held_next
);
    import mciq_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             held_reg;
    logic [CNT_W:0]   inc;
    logic [CNT_W:0]   sat;

    // Counter step, ceiling limit and event decision
    always_comb begin
        inc       = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};
        sat       = inc;
        cnt_next  = cnt_reg;
        held_next = held_reg;
        evt       = 1'b0;
        if (!mode) begin
            // button: count while pressed
            if (!active) begin
                cnt_next = '0;
            end else if (inc == {1'b0, thr.press}) begin
                cnt_next  = inc[CNT_W-1:0];
                held_next = 1'b0;
                evt       = 1'b1;
            end else if (inc == {1'b0, thr.hold}) begin
                cnt_next  = inc[CNT_W-1:0];
                held_next = 1'b1;
                evt       = 1'b1;
            end else begin
                if (inc > {1'b0, thr.hold})
                    sat = {1'b0, thr.hold} + {{CNT_W{1'b0}}, 1'b1};
                cnt_next = sat[CNT_W] ? {CNT_W{1'b1}} : sat[CNT_W-1:0];
            end
        end else begin
            // sensor: count while level differs from the held one
            if (held_reg == active) begin
                cnt_next = '0;
            end else if (inc == {1'b0, thr.level}) begin
                cnt_next  = inc[CNT_W-1:0];
                held_next = active;
                evt       = 1'b1;
            end else begin
                if (inc > {1'b0, thr.level})
                    sat = {1'b0, thr.level} + {{CNT_W{1'b0}}, 1'b1};
                cnt_next = sat[CNT_W] ? {CNT_W{1'b1}} : sat[CNT_W-1:0];
            end
        end
    end

    // State update once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            held_reg <= 1'b0;
        end else if (en) begin
            cnt_reg  <= cnt_next;
            held_reg <= held_next;
        end
    end

endmodule

/* hw/rtl/multi_channel_input_qualifier_top.sv */
// Top level of the multi-channel input qualifier: stream ports, config
// registers, input register, per-channel logic and result register.
// Depends on mciq_pkg and mciq_channel.
//
//  Channel | Direction | Item contents
//  s_      | in        | raw_levels (one bit per channel, low = active)
//  m_      | out       | event_mask, state_mask, any_event
//  cfg_    | in        | register writes, no read-back
//
// One item per cycle sustained while m_tready stays high; each item passes the
// input register, then the channel update into the result register.
// The channel counters update as the item moves into the result register.
// Reset (aresetn, synchronous) clears counters, held states and valid flags.
// A stalled result holds the input register; s_tready falls only when both
// stages are full.
module multi_channel_input_qualifier_top #(
    parameter int CHANNELS = mciq_pkg::CHANNELS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // raw_levels [CHANNELS-1:0], zero padded
    input  logic [((CHANNELS+7)/8)*8-1:0]           s_tdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // event_mask, state_mask, any_event (from the lowest bit), zero padded
    output logic [((2*CHANNELS+8)/8)*8-1:0]         m_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    cfg_we,
    input  logic [mciq_pkg::CFG_IDX_W-1:0]          cfg_addr,
    input  logic [mciq_pkg::CFG_W-1:0]              cfg_wdata
);
    import mciq_pkg::*;

    localparam int M_W = ((2*CHANNELS+8)/8)*8;
    localparam logic [CHANNELS-1:0] MODES_RST = MODES_RESET[CHANNELS-1:0];

    logic [CHANNELS-1:0] modes_reg;
    mciq_thr_t           thr_reg;
    logic                in_valid_reg;
    logic [CHANNELS-1:0] in_raw_reg;
    logic                out_valid_reg;
    logic [CHANNELS-1:0] evt_reg;
    logic [CHANNELS-1:0] state_reg;
    logic [CHANNELS-1:0] evt_next;
    logic [CHANNELS-1:0] state_next;
    logic                adv;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modes_reg     <= MODES_RST;
            thr_reg.press <= PRESS_RESET;
            thr_reg.hold  <= HOLD_RESET;
            thr_reg.level <= LEVEL_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_CHANNEL_MODES: modes_reg     <= cfg_wdata[CHANNELS-1:0];
                CFG_PRESS_TICKS:   thr_reg.press <= cfg_wdata;
                CFG_HOLD_TICKS:    thr_reg.hold  <= cfg_wdata;
                CFG_LEVEL_TICKS:   thr_reg.level <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: item moves on when the result register is free or drained
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid)
            in_raw_reg <= s_tdata[CHANNELS-1:0];
    end

    // Per-channel qualifiers
    for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
        mciq_channel u_ch (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .mode      (modes_reg[i]),
            .active    (!in_raw_reg[i]),
            .thr       (thr_reg),
            .evt       (evt_next[i]),
            .held_next (state_next[i])
        );
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            evt_reg   <= evt_next;
            state_reg <= state_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_W'({|evt_reg, state_reg, evt_reg});

endmodule

/* tb/sv/multi_channel_input_qualifier_top_test.sv */
// Testbench for the multi-channel input qualifier: debounces active-low pins
// into press, hold and level events, and checks every result item against a
// local predictor. Depends on mciq_pkg and multi_channel_input_qualifier_top.
module multi_channel_input_qualifier_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mciq_pkg::*;

    localparam int CH       = CHANNELS_DEF;
    localparam int S_W      = ((CH + 7) / 8) * 8;
    localparam int M_W      = ((2 * CH + 8) / 8) * 8;
    localparam int unsigned CNT_CEIL = (1 << CNT_W) - 1;

    // One result item: event_mask, state_mask, any_event from the lowest bit
    typedef struct packed {
        logic          any_event;
        logic [CH-1:0] state_mask;
        logic [CH-1:0] event_mask;
    } tick_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_W-1:0]       s_tdata   = '0;   // raw_levels
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_W-1:0]       m_tdata;          // event_mask, state_mask, any_event
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Predictor copy of registers and per-channel state
    logic [CH-1:0]  qual_modes;
    int unsigned    press_thr, hold_thr, level_thr;
    int unsigned    tick_count [CH];
    logic [CH-1:0]  held_level;

    tick_result_t   pending_ticks [$];
    tick_result_t   want;
    int             failures   = 0;
    bit             idle_on    = 1'b1;
    int             rx_holdoff = 0;

    multi_channel_input_qualifier_top #(.CHANNELS(CH)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #(24ms);
        $display("Test completed with failures");
        $finish;
    end

    // Advance the predictor by one scan tick
    function automatic tick_result_t qualify_tick(input logic [CH-1:0] raw);
        tick_result_t r;
        int unsigned  nxt;
        logic         active;
        int           ch;
        r = '0;
        for (ch = 0; ch < CH; ch++) begin
            active = !raw[ch];
            if (!qual_modes[ch]) begin
                // button: press then hold, saturate just past hold
                if (!active) begin
                    tick_count[ch] = 0;
                end else begin
                    nxt = tick_count[ch] + 1;
                    if (nxt == press_thr) begin
                        held_level[ch]   = 1'b0;
                        r.event_mask[ch] = 1'b1;
                    end else if (nxt == hold_thr) begin
                        held_level[ch]   = 1'b1;
                        r.event_mask[ch] = 1'b1;
                    end else if (nxt > hold_thr) begin
                        nxt = hold_thr + 1;
                    end
                    tick_count[ch] = (nxt > CNT_CEIL) ? CNT_CEIL : nxt;
                end
            end else begin
                // sensor: count while level differs from the held one
                if (held_level[ch] == active) begin
                    tick_count[ch] = 0;
                end else begin
                    nxt = tick_count[ch] + 1;
                    if (nxt == level_thr) begin
                        held_level[ch]   = active;
                        r.event_mask[ch] = 1'b1;
                    end else if (nxt > level_thr) begin
                        nxt = level_thr + 1;
                    end
                    tick_count[ch] = (nxt > CNT_CEIL) ? CNT_CEIL : nxt;
                end
            end
        end
        r.state_mask = held_level;
        r.any_event  = |r.event_mask;
        return r;
    endfunction

    // Offer one item, with random gaps ahead of it; predict once accepted
    task automatic send_levels(input logic [CH-1:0] raw);
        while (idle_on && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'(raw);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_ticks.push_back(qualify_tick(raw));
    endtask

    // Stop offering and wait until every expected item is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_ticks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_CHANNEL_MODES: qual_modes = value[CH-1:0];
            CFG_PRESS_TICKS:   press_thr  = 32'(value);
            CFG_HOLD_TICKS:    hold_thr   = 32'(value);
            CFG_LEVEL_TICKS:   level_thr  = 32'(value);
            default: ;
        endcase
    endtask

    // Write all four registers while the block is idle
    task automatic apply_settings(input logic [CH-1:0] modes, input logic [CFG_W-1:0] press,
                                  input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] level);
        logic [CFG_W-1:0] mode_word;
        wait_drained();
        mode_word          = CFG_W'($urandom);   // upper bits must be ignored
        mode_word[CH-1:0]  = modes;
        write_reg(CFG_CHANNEL_MODES, mode_word);
        write_reg(CFG_PRESS_TICKS, press);
        write_reg(CFG_HOLD_TICKS, hold);
        write_reg(CFG_LEVEL_TICKS, level);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [CFG_W-1:0] pick_ticks();
        case ($urandom_range(19))
            0:       return '0;
            1:       return 16'd65534;
            2:       return 16'd1;
            default: return CFG_W'($urandom_range(2, 12));
        endcase
    endfunction

    // Stable pin runs with random flips, plus one-tick glitches
    task automatic run_scan_phase(input int n_items);
        logic [CH-1:0] levels;
        int            run_len, k, sent;
        levels = CH'($urandom);
        sent   = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_levels(CH'($urandom));
                sent++;
            end else begin
                levels  = levels ^ CH'($urandom_range(1, (1 << CH) - 1));
                run_len = $urandom_range(1, 30);
                for (k = 0; k < run_len && sent < n_items; k++) begin
                    send_levels(levels);
                    sent++;
                end
            end
        end
    endtask

    // Reset values: button press at the default count, sensors still counting
    task automatic test_default_settings();
        int k;
        for (k = 0; k < 10; k++) send_levels('0);
        send_levels('1);
    endtask

    // Press equal to hold: press wins; one sensor takes its level at once
    task automatic test_press_equals_hold();
        int k;
        apply_settings(3'b100, 16'd2, 16'd2, 16'd1);
        for (k = 0; k < 3; k++) send_levels('0);
        send_levels('1);
    endtask

    // Press one past hold fires after the hold, then a press that never fires
    task automatic test_press_past_hold();
        int k;
        apply_settings('0, 16'd3, 16'd2, 16'd1);
        for (k = 0; k < 4; k++) send_levels(3'b010);
        apply_settings('0, 16'd6, 16'd2, 16'd1);
        for (k = 0; k < 3; k++) send_levels('0);
    endtask

    // Zero thresholds never fire; counters carry across the mode change
    task automatic test_zero_thresholds();
        apply_settings('1, '0, '0, '0);
        send_levels('0);
        send_levels('0);
        send_levels('1);
    endtask

    // Thresholds at the top of the 16-bit range stay silent over a short run
    task automatic test_top_thresholds();
        int k;
        apply_settings(3'b100, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (k = 0; k < 40; k++) send_levels('0);
    endtask

    // Random settings, one phase per setting, with back-pressure phases
    task automatic test_random_scans();
        int phase;
        logic [CH-1:0] modes;
        for (phase = 0; phase < 12; phase++) begin
            modes = (phase == 0) ? '0 : (phase == 1) ? '1 : CH'($urandom);
            apply_settings(modes, pick_ticks(), pick_ticks(), pick_ticks());
            if (phase == 3) idle_on = 1'b0;
            if (phase == 6) rx_holdoff = 300;
            run_scan_phase(150);
            idle_on = 1'b1;
        end
    endtask

    // Receiver: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_holdoff > 0) begin
                rx_holdoff--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 34);
            end
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ticks.size() == 0) begin
                $display("%0t: result item %h with nothing expected", $time, m_tdata);
                failures++;
            end else begin
                want = pending_ticks.pop_front();
                if (m_tdata[CH-1:0] !== want.event_mask) begin
                    $display("%0t: event_mask expected %b actual %b",
                             $time, want.event_mask, m_tdata[CH-1:0]);
                    failures++;
                end
                if (m_tdata[2*CH-1:CH] !== want.state_mask) begin
                    $display("%0t: state_mask expected %b actual %b",
                             $time, want.state_mask, m_tdata[2*CH-1:CH]);
                    failures++;
                end
                if (m_tdata[2*CH] !== want.any_event) begin
                    $display("%0t: any_event expected %b actual %b",
                             $time, want.any_event, m_tdata[2*CH]);
                    failures++;
                end
            end
        end
    end

    // Sequence of tests
    initial begin
        qual_modes = MODES_RESET[CH-1:0];
        press_thr  = 32'(PRESS_RESET);
        hold_thr   = 32'(HOLD_RESET);
        level_thr  = 32'(LEVEL_RESET);
        held_level = '0;
        foreach (tick_count[i]) tick_count[i] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_settings();
        test_press_equals_hold();
        test_press_past_hold();
        test_zero_thresholds();
        test_random_scans();
        test_top_thresholds();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mciq_pkg.sv
hw/rtl/mciq_channel.sv
hw/rtl/multi_channel_input_qualifier_top.sv
tb/sv/multi_channel_input_qualifier_top_test.sv
